### src/sacfm_pkg.sv
// Shared types, constants and the CRC-6 function for the angle frame unit.
// No dependencies.
`default_nettype none

package sacfm_pkg;

    localparam int FRAME_BITS  = 24;
    localparam int PAYLOAD_BITS = 18;
    localparam int CRC_BITS    = 6;
    localparam int ANGLE_BITS  = 14;
    localparam int OFFSET_BITS = 32;
    localparam int POS_BITS    = 64;
    localparam int QUEUE_DEPTH = 2;

    // x^6 + x + 1, leading term implicit
    localparam logic [CRC_BITS-1:0] CRC_POLY_LOW = 6'h03;

    localparam logic [1:0] FIELD_NORMAL = 2'd0;

    localparam logic signed [ANGLE_BITS:0] HALF_TURN_POS = 15'sd8192;
    localparam logic signed [ANGLE_BITS:0] HALF_TURN_NEG = -15'sd8192;

    // configuration register indexes
    localparam logic REG_COUNT_OFFSET      = 1'b0;
    localparam logic REG_REVERSE_DIRECTION = 1'b1;

    typedef struct packed {
        logic                  frame_valid;
        logic                  crc_ok;
        logic [1:0]            field_status;
        logic                  track_ok;
        logic                  button_pressed;
        logic [ANGLE_BITS-1:0] angle;
    } dec_word_t;

    // MSB-first CRC, zero initial value; unrolls to a small XOR tree
    function automatic logic [CRC_BITS-1:0] crc6(input logic [PAYLOAD_BITS-1:0] data);
        logic [CRC_BITS-1:0] crc;
        logic                fb;
        crc = '0;
        for (int i = PAYLOAD_BITS - 1; i >= 0; i--)
        begin
            fb  = crc[CRC_BITS-1] ^ data[i];
            crc = {crc[CRC_BITS-2:0], 1'b0} ^ (fb ? CRC_POLY_LOW : '0);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### src/ssi_angle_frame_crc6_multiturn_unit.sv
// Top level of the serial angle frame decoder with multi-turn count.
// Depends on sacfm_pkg, sacfm_front, sacfm_fifo and sacfm_back.
//
// Input channel: in_valid/in_stall with the 24-bit frame word. Output channel:
// out_valid/out_stall with the decoded fields and the 64-bit signed position.
// One result word per frame word, in order.
// Path: front register, two-entry queue, state update stage, offset add
// stage, negate into the output register, then out_valid. Throughput is one
// word per cycle while out_stall is low; the state update of one word feeds
// the next in the same stage.
// When out_stall is held the back end fills, then the queue, then the front
// register, after which in_stall rises; no word is dropped.
// Reset clears the turn count, previous angle, baseline flag, offset and
// direction; the first valid frame after reset sets the baseline. There is
// no clearing pass. Configuration writes via cfg_we/cfg_index/cfg_data take
// effect at once and should be made while no word is in flight.
`default_nettype none

module ssi_angle_frame_crc6_multiturn_unit
    import sacfm_pkg::*;
#(
    parameter int TURN_BITS = 48
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [OFFSET_BITS-1:0] cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [FRAME_BITS-1:0]  frame,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        frame_valid,
    output logic                        crc_ok,
    output logic [1:0]                  field_status,
    output logic                        track_ok,
    output logic                        button_pressed,
    output logic [ANGLE_BITS-1:0]       angle,
    output logic signed [POS_BITS-1:0]  position
);

    logic      push_valid;
    logic      push_ready;
    dec_word_t push_word;
    logic      pop_valid;
    logic      pop_ready;
    dec_word_t pop_word;
    dec_word_t out_word;

    sacfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame      (frame),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    sacfm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    sacfm_back #(
        .TURN_BITS (TURN_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .position  (position)
    );

    assign frame_valid    = out_word.frame_valid;
    assign crc_ok         = out_word.crc_ok;
    assign field_status   = out_word.field_status;
    assign track_ok       = out_word.track_ok;
    assign button_pressed = out_word.button_pressed;
    assign angle          = out_word.angle;

endmodule

`default_nettype wire

### src/sacfm_front.sv
// Front end: takes frame words, checks the CRC and unpacks the fields.
// Depends on sacfm_pkg.
`default_nettype none

module sacfm_front
    import sacfm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FRAME_BITS-1:0] frame,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output dec_word_t                  push_word
);

    logic      hold_valid_reg;
    dec_word_t hold_word_reg;
    dec_word_t dec_next;
    logic      take;

    always_comb
    begin
        dec_next.crc_ok         = crc6(frame[FRAME_BITS-1:CRC_BITS]) == frame[CRC_BITS-1:0];
        dec_next.field_status   = frame[7:6];
        dec_next.track_ok       = ~frame[9];
        dec_next.button_pressed = frame[8];
        dec_next.angle          = frame[FRAME_BITS-1:FRAME_BITS-ANGLE_BITS];
        dec_next.frame_valid    = dec_next.crc_ok && dec_next.track_ok
                                  && (dec_next.field_status == FIELD_NORMAL);
    end

    assign in_stall   = hold_valid_reg && !push_ready;
    assign take       = in_valid && !in_stall;
    assign push_valid = hold_valid_reg;
    assign push_word  = hold_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_word_reg <= dec_next;
        end
    end

endmodule

`default_nettype wire

### src/sacfm_fifo.sv
// Short queue of decoded words between front and back end.
// Depends on sacfm_pkg.
`default_nettype none

module sacfm_fifo
    import sacfm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire dec_word_t push_word,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output dec_word_t      pop_word
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    dec_word_t           mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                push;
    logic                pop;

    assign push_ready = cnt_reg != CNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

### src/sacfm_back.sv
// Back end: turn tracking, position arithmetic and the output register.
// Holds the configuration registers. Depends on sacfm_pkg.
`default_nettype none

module sacfm_back
    import sacfm_pkg::*;
#(
    parameter int TURN_BITS = 48
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [OFFSET_BITS-1:0] cfg_data,
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  wire dec_word_t              pop_word,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output dec_word_t                   out_word,
    output logic signed [POS_BITS-1:0]  position
);

    localparam int TP_BITS = TURN_BITS + ANGLE_BITS;

    logic signed [OFFSET_BITS-1:0] count_offset_reg;
    logic                          reverse_reg;

    logic [TURN_BITS-1:0]  turn_reg,  turn_next;
    logic [ANGLE_BITS-1:0] prev_reg,  prev_next;
    logic                  base_reg,  base_next;
    logic signed [ANGLE_BITS:0] delta;

    // stage 1: updated state snapshot
    logic                      v1_reg;
    dec_word_t                 w1_reg;
    logic signed [TP_BITS-1:0] tp1_reg;
    logic                      zero1_reg;
    // stage 2: offset added
    logic                       v2_reg;
    dec_word_t                  w2_reg;
    logic signed [POS_BITS-1:0] sum2_reg;
    // output register
    logic                       out_valid_reg;
    dec_word_t                  out_word_reg;
    logic signed [POS_BITS-1:0] position_reg;

    logic rdy1, rdy2, rdy3, take;

    assign rdy3      = !out_valid_reg || !out_stall;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign pop_ready = rdy1;
    assign take      = pop_valid && rdy1;

    assign delta = $signed({1'b0, pop_word.angle}) - $signed({1'b0, prev_reg});

    always_comb
    begin
        turn_next = turn_reg;
        prev_next = prev_reg;
        base_next = base_reg;
        if (pop_word.frame_valid)
        begin
            prev_next = pop_word.angle;
            base_next = 1'b1;
            if (!base_reg)
            begin
                turn_next = '0;
            end
            else if (delta > HALF_TURN_POS)
            begin
                turn_next = turn_reg - TURN_BITS'(1);
            end
            else if (delta < HALF_TURN_NEG)
            begin
                turn_next = turn_reg + TURN_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_offset_reg <= '0;
            reverse_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COUNT_OFFSET:      count_offset_reg <= cfg_data;
                REG_REVERSE_DIRECTION: reverse_reg      <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg      <= '0;
            prev_reg      <= '0;
            base_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                turn_reg <= turn_next;
                prev_reg <= prev_next;
                base_reg <= base_next;
            end
            if (rdy1)
            begin
                v1_reg <= pop_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            w1_reg    <= pop_word;
            tp1_reg   <= {turn_next, prev_next};
            zero1_reg <= !base_next;
        end
        if (rdy2 && v1_reg)
        begin
            w2_reg   <= w1_reg;
            sum2_reg <= zero1_reg ? '0
                        : POS_BITS'(tp1_reg) + POS_BITS'(count_offset_reg);
        end
        if (rdy3 && v2_reg)
        begin
            out_word_reg <= w2_reg;
            position_reg <= reverse_reg ? POS_BITS'(0) - sum2_reg : sum2_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign position  = position_reg;

`ifndef NO_ASSERTIONS
    a_base_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(base_reg))
        else $error("baseline flag dropped");

    a_turn_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(turn_reg) |-> $past(take && pop_word.frame_valid && base_reg))
        else $error("turn count moved without a valid word");
`endif

endmodule

`default_nettype wire
